// ===== rtl/core/jse_pkg.sv =====
package jse_pkg;

  // input and output words
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_word_t;

  // work handed from the classifier to the emitter
  typedef enum logic [1:0] {
    KindChar = 2'd0,  // one plain character, in lo[7:0]
    KindEsc  = 2'd1,  // backslash + lo[7:0]
    KindU16  = 2'd2,  // \u + four hex digits of lo
    KindPair = 2'd3   // \u hi, then \u lo
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] hi;
    logic [15:0] lo;
  } job_t;

  // job queue
  localparam int QAw    = 2;
  localparam int QDepth = 1 << QAw;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAw:0]   count;
  } q_stat_t;

  // characters
  localparam logic [7:0] AsciiQuote = 8'h22;
  localparam logic [7:0] AsciiBslash = 8'h5C;
  localparam logic [7:0] AsciiLowU  = 8'h75;
  localparam logic [7:0] AsciiLowR  = 8'h72;
  localparam logic [7:0] AsciiLowN  = 8'h6E;
  localparam logic [7:0] AsciiLowT  = 8'h74;
  localparam logic [7:0] AsciiLowB  = 8'h62;
  localparam logic [7:0] AsciiLowF  = 8'h66;
  localparam logic [7:0] CtrlBs     = 8'h08;
  localparam logic [7:0] CtrlTab    = 8'h09;
  localparam logic [7:0] CtrlLf     = 8'h0A;
  localparam logic [7:0] CtrlFf     = 8'h0C;
  localparam logic [7:0] CtrlCr     = 8'h0D;
  localparam logic [7:0] PrintLow   = 8'h20;
  localparam logic [7:0] PrintHigh  = 8'h7E;

  // UTF-8 lead byte patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;

  localparam logic [20:0] CpPlane1 = 21'h10000;
  localparam logic [20:0] CpMax    = 21'h10FFFF;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/jse_front.sv =====
module jse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jse_pkg::in_word_t  in_word_i,
  input  logic               q_full_i,
  output logic               push_o,
  output jse_pkg::job_t      job_o
);
  import jse_pkg::*;

  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic [20:0] acc_shift;
  logic [20:0] cp_off;
  logic [7:0]  b;
  logic        accept;
  logic        want;
  job_t        job;

  assign b          = in_word_i.in_byte;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign acc_shift  = {acc_q[14:0], b[5:0]};
  assign cp_off     = acc_shift - CpPlane1;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    want   = 1'b0;
    job    = '0;
    if (pend_q != 2'd0) begin
      acc_d  = acc_shift;
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        if (acc_shift < CpPlane1) begin
          want     = 1'b1;
          job.kind = KindU16;
          job.lo   = acc_shift[15:0];
        end else if (acc_shift <= CpMax) begin
          want     = 1'b1;
          job.kind = KindPair;
          job.hi   = {6'b110110, cp_off[19:10]};
          job.lo   = {6'b110111, cp_off[9:0]};
        end
      end
    end else begin
      job.kind = KindEsc;
      case (b)
        AsciiQuote, AsciiBslash: begin
          want   = 1'b1;
          job.lo = {8'd0, b};
        end
        CtrlCr: begin
          want   = 1'b1;
          job.lo = {8'd0, AsciiLowR};
        end
        CtrlLf: begin
          want   = 1'b1;
          job.lo = {8'd0, AsciiLowN};
        end
        CtrlTab: begin
          want   = 1'b1;
          job.lo = {8'd0, AsciiLowT};
        end
        CtrlBs: begin
          want   = 1'b1;
          job.lo = {8'd0, AsciiLowB};
        end
        CtrlFf: begin
          want   = 1'b1;
          job.lo = {8'd0, AsciiLowF};
        end
        default: begin
          if (b >= PrintLow && b <= PrintHigh) begin
            want     = 1'b1;
            job.kind = KindChar;
            job.lo   = {8'd0, b};
          end else if ((b & Lead2Mask) == Lead2Tag) begin
            pend_d = 2'd1;
            acc_d  = {16'd0, b[4:0]};
          end else if ((b & Lead3Mask) == Lead3Tag) begin
            pend_d = 2'd2;
            acc_d  = {17'd0, b[3:0]};
          end else if ((b & Lead4Mask) == Lead4Tag) begin
            pend_d = 2'd3;
            acc_d  = {18'd0, b[2:0]};
          end
        end
      endcase
    end
    if (in_word_i.end_of_string) begin
      pend_d = 2'd0;
      acc_d  = '0;
    end
  end

  assign push_o = accept && want;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ===== rtl/core/jse_queue.sv =====
module jse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jse_pkg::job_t     wdata_i,
  input  logic              pop_i,
  output jse_pkg::job_t     rdata_o,
  output jse_pkg::q_stat_t  stat_o
);
  import jse_pkg::*;

  localparam logic [QAw:0] CountFull = (QAw + 1)'(QDepth);

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign rdata_o      = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CountFull);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

// ===== rtl/core/jse_back.sv =====
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  jse_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jse_pkg::out_word_t out_word_o
);
  import jse_pkg::*;

  localparam logic [3:0] LastChar = 4'd0;
  localparam logic [3:0] LastEsc  = 4'd1;
  localparam logic [3:0] LastU16  = 4'd5;
  localparam logic [3:0] LastPair = 4'd11;
  localparam logic [3:0] HalfLen  = 4'd6;

  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q;
  logic [3:0]  last_idx;
  logic        is_last;
  logic        second;
  logic [3:0]  pos;
  logic [15:0] val;
  logic [3:0]  nib;
  logic [7:0]  ch;
  logic        emit;

  assign emit = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (head_i.kind)
      KindChar: last_idx = LastChar;
      KindEsc:  last_idx = LastEsc;
      KindU16:  last_idx = LastU16;
      default:  last_idx = LastPair;
    endcase
  end

  assign is_last = (idx_q == last_idx);
  assign second  = (idx_q >= HalfLen);
  assign pos     = second ? (idx_q - HalfLen) : idx_q;
  assign val     = (head_i.kind == KindPair && !second) ? head_i.hi : head_i.lo;

  always_comb begin
    case (pos)
      4'd2:    nib = val[15:12];
      4'd3:    nib = val[11:8];
      4'd4:    nib = val[7:4];
      default: nib = val[3:0];
    endcase
  end

  always_comb begin
    case (head_i.kind)
      KindChar: ch = head_i.lo[7:0];
      KindEsc:  ch = (idx_q == 4'd0) ? AsciiBslash : head_i.lo[7:0];
      default: begin
        if (pos == 4'd0) begin
          ch = AsciiBslash;
        end else if (pos == 4'd1) begin
          ch = AsciiLowU;
        end else begin
          ch = hex_char(nib);
        end
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? 4'd0 : idx_q + 4'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_char <= ch;
      out_q.run_last <= is_last;
    end
  end

  assign pop_o       = emit && is_last;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/json_string_escaper.sv =====
// JSON string escaper: UTF-8 bytes in, escaped JSON text out.
// Input channel: in_valid_i / in_stall_o / in_word_i carries one source byte per
//   word plus end_of_string on the final byte of a string.
// Output channel: out_valid_o / out_stall_i / out_word_o carries one ASCII char
//   per word; run_last marks the final char produced by one input byte.
// A word moves on a rising edge with valid high and stall low.
// Structure: a classifier decodes UTF-8 and turns each byte into a job (plain
//   char, two-char escape, \uXXXX, or surrogate pair), a 4-entry job queue,
//   and an emitter that walks each job one char per cycle, unless the receiver stalls, into an output reg.
// With the emitter idle, an accepted byte's job is written into the queue and
//   then loaded by the emitter into out_word_o, from which its first char can leave.
// Throughput: the emitter gives one char per cycle unless the receiver stalls;
//   a byte turns into 1, 2, 6 or 12 chars of emitter work; bytes that give no
//   output (lead bytes, continuation bytes short of the last, dropped bytes)
//   cost none there. Input is taken every cycle while the job queue has room.
// Reset: clears the decoder state, the queue and the output valid flag, not the
//   output char register. No clearing pass; the block accepts input right after reset.
// Receiver stall: the output word holds, the emitter waits, the queue fills,
//   and then in_stall_o rises.
module json_string_escaper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jse_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jse_pkg::out_word_t out_word_o
);
  import jse_pkg::*;

  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_head;
  q_stat_t q_stat;

  jse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .job_o      (job_in)
  );

  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_head),
    .stat_o  (q_stat)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_stat.empty),
    .head_i      (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // queue never overflows or underflows
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("job popped from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= (QAw + 1)'(QDepth)) else $error("queue count out of range");

  // a finished job leaves exactly when its last char is loaded
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && out_word_o.run_last)
    else $error("job retired without run_last");

endmodule
